/* design/pwt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_pkg
// Types and constants shared by the protobuf wire tokenizer modules.
// ----------------------------------------------------------------------------
package pwt_pkg;

  localparam int unsigned FIELD_W = 29;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned SHIFT_W = 4;

  // Longest legal varint, in bytes.
  localparam logic [SHIFT_W-1:0] VARINT_MAX_BYTES = 4'd10;
  localparam logic [SHIFT_W-1:0] FIX32_BYTES      = 4'd4;
  localparam logic [SHIFT_W-1:0] FIX64_BYTES      = 4'd8;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_FIX32   = 3'd4,
    PH_FIX64   = 3'd5,
    PH_DROP    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_SCALAR  = 3'd0,
    KIND_LENGTH  = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_END     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TRUNCATED = 2'd1,
    ERR_TOO_LONG  = 2'd2,
    ERR_BAD_WIRE  = 2'd3
  } err_t;

  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_FIX64  = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_FIX32  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } byte_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] field_id;
    logic [2:0]         wire_code;
    logic [VALUE_W-1:0] value;
    logic [7:0]         payload_byte;
    err_t               error_code;
    logic               at_end;
  } token_t;

  // Handshake between the input register and the decode stage.
  typedef struct packed {
    logic       valid;
    byte_item_t item;
  } stage_t;

endpackage

/* design/pwt_byte_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_byte_if
// Input channel: one buffer byte and its end-of-buffer mark per item.
// ----------------------------------------------------------------------------
interface pwt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

/* design/pwt_token_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_token_if
// Output channel: one decoded token per item.
// ----------------------------------------------------------------------------
interface pwt_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [28:0] field_id;
  logic [2:0]  wire_code;
  logic [63:0] value;
  logic [7:0]  payload_byte;
  logic [1:0]  error_code;
  logic        at_end;

  modport source (output valid, kind, field_id, wire_code, value, payload_byte,
                  error_code, at_end, input ready);
  modport sink   (input valid, kind, field_id, wire_code, value, payload_byte,
                  error_code, at_end, output ready);
endinterface

/* design/pwt_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_cfg_if
// Configuration write channel for the emit_payload register.
// ----------------------------------------------------------------------------
interface pwt_cfg_if;
  logic valid;
  logic ready;
  logic emit_payload;

  modport source (output valid, emit_payload, input ready);
  modport sink   (input valid, emit_payload, output ready);
endinterface

/* design/protobuf_wire_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protobuf_wire_tokenizer
// Splits a protobuf message buffer, one byte per item, into field tokens.
//
//   Channel  Role   Item
//   bytes    sink   data_byte, end_of_buffer
//   tokens   source kind, field_id, wire_code, value, payload_byte,
//                   error_code, at_end
//   cfg      sink   emit_payload (write only, always ready)
//
// One byte is taken per clock cycle unless a stall on tokens fills the input
// register. A byte passes the input register, then the decode logic and the
// parse state registers update together with the result register, which
// presents any token for the byte. A stall on tokens holds the result register
// and the input register, and bytes.ready drops only while both are full and
// tokens is not ready. Reset clears the parse state and sets emit_payload to 1.
// ----------------------------------------------------------------------------
module protobuf_wire_tokenizer (
  input  logic         clk,
  input  logic         rst,
  pwt_byte_if.sink     bytes,
  pwt_token_if.source  tokens,
  pwt_cfg_if.sink      cfg
);

  logic            emit_payload;
  logic            take;
  pwt_pkg::stage_t stage;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_payload <= 1'b1;
    end else if (cfg.valid) begin
      emit_payload <= cfg.emit_payload;
    end
  end

  pwt_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .take  (take),
    .stage (stage)
  );

  pwt_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .emit_payload (emit_payload),
    .stage        (stage),
    .take         (take),
    .tokens       (tokens)
  );

endmodule

/* design/pwt_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_in_stage
// Input register: captures one byte item and holds it until decode takes it.
// ----------------------------------------------------------------------------
module pwt_in_stage (
  input  logic             clk,
  input  logic             rst,
  pwt_byte_if.sink         bytes,
  input  logic             take,
  output pwt_pkg::stage_t  stage
);

  logic                 held;
  pwt_pkg::byte_item_t  item;

  // Refill in the same cycle the held item moves on.
  assign bytes.ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (bytes.ready) begin
      held <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      item.data_byte     <= bytes.data_byte;
      item.end_of_buffer <= bytes.end_of_buffer;
    end
  end

  assign stage.valid = held;
  assign stage.item  = item;

endmodule

/* design/pwt_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_decode
// Parse state, per-byte decode logic and the result register.
// ----------------------------------------------------------------------------
module pwt_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            emit_payload,
  input  pwt_pkg::stage_t stage,
  output logic            take,
  pwt_token_if.source     tokens
);

  pwt_pkg::phase_t                 phase, phase_next;
  logic [pwt_pkg::VALUE_W-1:0]     acc, acc_next;
  logic [pwt_pkg::SHIFT_W-1:0]     shift_count, shift_next;
  logic [pwt_pkg::FIELD_W-1:0]     cur_field, cur_field_next;
  logic [2:0]                      cur_wire, cur_wire_next;
  logic [pwt_pkg::VALUE_W-1:0]     remaining, remaining_next;

  logic [pwt_pkg::VALUE_W-1:0]     acc_vi, acc_fx, rem_dec;
  logic [pwt_pkg::SHIFT_W-1:0]     shift_inc, need;
  logic [7:0]                      b;
  logic                            last, in_tag;
  logic                            res_fire, err_hit, err_with_field;
  pwt_pkg::err_t                   err_code;
  pwt_pkg::token_t                 res, out_reg;
  logic                            out_valid, out_free;

  assign b         = stage.item.data_byte;
  assign last      = stage.item.end_of_buffer;
  assign out_free  = !out_valid || tokens.ready;
  assign take      = stage.valid && out_free;
  assign shift_inc = shift_count + 4'd1;
  assign rem_dec   = remaining - 64'd1;
  assign need      = (phase == pwt_pkg::PH_FIX32) ? pwt_pkg::FIX32_BYTES : pwt_pkg::FIX64_BYTES;
  assign in_tag    = (phase != pwt_pkg::PH_VARINT) && (phase != pwt_pkg::PH_LEN);

  // Each varint byte lands in its own 7-bit group; the tenth keeps only bit 0.
  always_comb begin
    acc_vi = acc;
    for (int i = 0; i < 9; i++) begin
      if (shift_count == 4'(i)) begin
        acc_vi[7*i +: 7] = acc[7*i +: 7] | b[6:0];
      end
    end
    if (shift_count == 4'd9) begin
      acc_vi[63] = acc[63] | b[0];
    end
  end

  always_comb begin
    acc_fx = acc;
    for (int j = 0; j < 8; j++) begin
      if (shift_count == 4'(j)) begin
        acc_fx[8*j +: 8] = acc[8*j +: 8] | b;
      end
    end
  end

  // Next phase. The last byte of a buffer always returns to the tag phase.
  always_comb begin
    phase_next = phase;
    if (last) begin
      phase_next = pwt_pkg::PH_TAG;
    end else if (err_hit) begin
      phase_next = pwt_pkg::PH_DROP;
    end else begin
      case (phase)
        pwt_pkg::PH_DROP: begin
          phase_next = pwt_pkg::PH_DROP;
        end

        pwt_pkg::PH_PAYLOAD: begin
          if (rem_dec == '0) begin
            phase_next = pwt_pkg::PH_TAG;
          end
        end

        pwt_pkg::PH_FIX32, pwt_pkg::PH_FIX64: begin
          if (shift_inc >= need) begin
            phase_next = pwt_pkg::PH_TAG;
          end
        end

        // Tag, varint value and length varint; the unused phase code acts as a tag.
        default: begin
          if (b[7]) begin
            if (in_tag) begin
              phase_next = pwt_pkg::PH_TAG;
            end
          end else if (in_tag) begin
            case (acc_vi[2:0])
              pwt_pkg::WIRE_VARINT: phase_next = pwt_pkg::PH_VARINT;
              pwt_pkg::WIRE_FIX64:  phase_next = pwt_pkg::PH_FIX64;
              pwt_pkg::WIRE_LEN:    phase_next = pwt_pkg::PH_LEN;
              pwt_pkg::WIRE_FIX32:  phase_next = pwt_pkg::PH_FIX32;
              default:              phase_next = pwt_pkg::PH_TAG;
            endcase
          end else if (phase == pwt_pkg::PH_LEN && acc_vi != '0) begin
            phase_next = pwt_pkg::PH_PAYLOAD;
          end else begin
            phase_next = pwt_pkg::PH_TAG;
          end
        end
      endcase
    end
  end

  always_comb begin
    acc_next       = acc;
    shift_next     = shift_count;
    cur_field_next = cur_field;
    cur_wire_next  = cur_wire;
    remaining_next = remaining;
    res            = '0;
    res_fire       = 1'b0;
    err_hit        = 1'b0;
    err_with_field = 1'b0;
    err_code       = pwt_pkg::ERR_NONE;

    case (phase)
      pwt_pkg::PH_DROP: begin
        if (last) begin
          res_fire   = 1'b1;
          res.kind   = pwt_pkg::KIND_END;
          res.at_end = 1'b1;
        end
      end

      pwt_pkg::PH_PAYLOAD: begin
        remaining_next = rem_dec;
        if (rem_dec != '0 && last) begin
          err_hit        = 1'b1;
          err_code       = pwt_pkg::ERR_TRUNCATED;
          err_with_field = 1'b1;
        end else begin
          if (emit_payload) begin
            res_fire         = 1'b1;
            res.kind         = pwt_pkg::KIND_PAYLOAD;
            res.field_id     = cur_field;
            res.wire_code    = pwt_pkg::WIRE_LEN;
            res.payload_byte = b;
            res.at_end       = last;
          end else if (last) begin
            res_fire   = 1'b1;
            res.kind   = pwt_pkg::KIND_END;
            res.at_end = 1'b1;
          end
        end
      end

      pwt_pkg::PH_FIX32, pwt_pkg::PH_FIX64: begin
        acc_next   = acc_fx;
        shift_next = shift_inc;
        if (shift_inc >= need) begin
          acc_next      = '0;
          shift_next    = '0;
          res_fire      = 1'b1;
          res.kind      = pwt_pkg::KIND_SCALAR;
          res.field_id  = cur_field;
          res.wire_code = cur_wire;
          res.value     = acc_fx;
          res.at_end    = last;
        end else if (last) begin
          err_hit        = 1'b1;
          err_code       = pwt_pkg::ERR_TRUNCATED;
          err_with_field = 1'b1;
        end
      end

      // Tag, varint value and length varint; the unused phase code acts as a tag.
      default: begin
        acc_next = acc_vi;
        if (b[7]) begin
          shift_next     = shift_inc;
          err_with_field = !in_tag;
          if (shift_inc >= pwt_pkg::VARINT_MAX_BYTES) begin
            err_hit  = 1'b1;
            err_code = pwt_pkg::ERR_TOO_LONG;
          end else if (last) begin
            err_hit  = 1'b1;
            err_code = pwt_pkg::ERR_TRUNCATED;
          end
        end else begin
          acc_next   = '0;
          shift_next = '0;
          if (in_tag) begin
            cur_field_next = acc_vi[31:3];
            cur_wire_next  = acc_vi[2:0];
            err_with_field = 1'b1;
            case (acc_vi[2:0])
              pwt_pkg::WIRE_VARINT, pwt_pkg::WIRE_FIX64,
              pwt_pkg::WIRE_LEN, pwt_pkg::WIRE_FIX32: begin
              end
              default: begin
                err_hit  = 1'b1;
                err_code = pwt_pkg::ERR_BAD_WIRE;
              end
            endcase
            // A tag that completes on the last byte has no value behind it.
            if (!err_hit && last) begin
              err_hit  = 1'b1;
              err_code = pwt_pkg::ERR_TRUNCATED;
            end
          end else if (phase == pwt_pkg::PH_VARINT) begin
            res_fire      = 1'b1;
            res.kind      = pwt_pkg::KIND_SCALAR;
            res.field_id  = cur_field;
            res.wire_code = cur_wire;
            res.value     = acc_vi;
            res.at_end    = last;
          end else if (acc_vi == '0) begin
            res_fire      = 1'b1;
            res.kind      = pwt_pkg::KIND_LENGTH;
            res.field_id  = cur_field;
            res.wire_code = pwt_pkg::WIRE_LEN;
            res.at_end    = last;
          end else if (last) begin
            err_hit        = 1'b1;
            err_code       = pwt_pkg::ERR_TRUNCATED;
            err_with_field = 1'b1;
          end else begin
            remaining_next = acc_vi;
            res_fire       = 1'b1;
            res.kind       = pwt_pkg::KIND_LENGTH;
            res.field_id   = cur_field;
            res.wire_code  = pwt_pkg::WIRE_LEN;
            res.value      = acc_vi;
            res.at_end     = last;
          end
        end
      end
    endcase

    if (err_hit) begin
      res            = '0;
      res_fire       = 1'b1;
      res.kind       = pwt_pkg::KIND_ERROR;
      res.error_code = err_code;
      res.at_end     = last;
      res.field_id   = err_with_field ? cur_field_next : '0;
      res.wire_code  = err_with_field ? cur_wire_next : 3'd0;
    end

    // The last byte of a buffer returns all parse state to its reset value.
    if (last) begin
      acc_next       = '0;
      shift_next     = '0;
      cur_field_next = '0;
      cur_wire_next  = '0;
      remaining_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= pwt_pkg::PH_TAG;
      acc         <= '0;
      shift_count <= '0;
      cur_field   <= '0;
      cur_wire    <= '0;
      remaining   <= '0;
    end else if (take) begin
      phase       <= phase_next;
      acc         <= acc_next;
      shift_count <= shift_next;
      cur_field   <= cur_field_next;
      cur_wire    <= cur_wire_next;
      remaining   <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= take && res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_fire) begin
      out_reg <= res;
    end
  end

  assign tokens.valid        = out_valid;
  assign tokens.kind         = out_reg.kind;
  assign tokens.field_id     = out_reg.field_id;
  assign tokens.wire_code    = out_reg.wire_code;
  assign tokens.value        = out_reg.value;
  assign tokens.payload_byte = out_reg.payload_byte;
  assign tokens.error_code   = out_reg.error_code;
  assign tokens.at_end       = out_reg.at_end;

endmodule
